// ===== rtl/dtq_pkg.sv =====
// Shared constants, codes and control structs for the deadline timer queue.
package dtq_pkg;

  localparam int SLOTS   = 32;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int OWNERS  = 16;
  localparam int OWN_W   = $clog2(OWNERS);
  localparam int DEPTH_NEXT  = 16;
  localparam int DEPTH_DELAY = 16;
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = 5;

  localparam logic [2:0] REQ_ADD_NEXT   = 3'd0;
  localparam logic [2:0] REQ_ADD_DELAY  = 3'd1;
  localparam logic [2:0] REQ_CANCEL_ID  = 3'd2;
  localparam logic [2:0] REQ_CANCEL_OWN = 3'd3;
  localparam logic [2:0] REQ_PROMO_NEXT = 3'd4;
  localparam logic [2:0] REQ_PROMO_DLY  = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_STOPPING = 3'd1;
  localparam logic [2:0] ST_CAPACITY = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_DUE      = 3'd6;
  localparam logic [2:0] ST_NONE_DUE = 3'd7;

  localparam logic [1:0] CFG_NEXT_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_DELAY_LIMIT = 2'd1;
  localparam logic [1:0] CFG_STOPPING    = 2'd2;

  typedef enum logic [1:0] {CK_RESULT, CK_SCAN, CK_DROP} chk_kind_t;
  typedef enum logic [1:0] {DK_FINAL, DK_MORE, DK_RESCAN} dec_kind_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan_init;
    logic scan_step;
    logic decide;
  } cmd_t;

  typedef struct packed {
    chk_kind_t chk;
    logic      scan_done;
    dec_kind_t dec;
  } sts_t;

endpackage

// ===== rtl/dtq_dp.sv =====
// Datapath: wait table, request registers, slot scan and result register.
module dtq_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  dtq_pkg::cmd_t                cmd,
  output dtq_pkg::sts_t                sts,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [4:0]                   cfg_wdata,
  input  logic [2:0]                   req_type,
  input  logic [62:0]                  duration_ns,
  input  logic [4:0]                   target_id,
  input  logic [4:0]                   owner_slot,
  input  logic [62:0]                  now_elapsed,
  input  logic [63:0]                  now_step,
  output logic [2:0]                   status,
  output logic [4:0]                   out_id,
  output logic [4:0]                   out_owner,
  output logic                         last
);

  localparam int SW = dtq_pkg::SLOT_W;
  localparam int OW = dtq_pkg::OWN_W;
  localparam int CW = dtq_pkg::CNT_W;

  // request
  logic [2:0]  r_type;
  logic [62:0] r_dur, r_el;
  logic [4:0]  r_tid, r_own;
  logic [63:0] r_st;

  // configuration
  logic [4:0] next_limit, delay_limit;
  logic       stopping;

  // wait table
  logic [dtq_pkg::SLOTS-1:0] used;
  logic                      isd   [dtq_pkg::SLOTS];
  logic [OW-1:0]             owner [dtq_pkg::SLOTS];
  logic [SW-1:0]             rank  [dtq_pkg::SLOTS];
  logic [62:0]               dl    [dtq_pkg::SLOTS];
  logic [63:0]               ms    [dtq_pkg::SLOTS];
  logic [CW-1:0]             fifo_count, heap_count;
  logic [63:0]               order_cnt;

  // scan
  logic [SW-1:0] idx, best_id, best_rank;
  logic          found, best_isd;
  logic [62:0]   best_dl;
  logic [63:0]   best_ms;
  logic [OW-1:0] best_own;

  // promote bookkeeping
  logic          have_pend;
  logic [SW-1:0] pend_id;
  logic [OW-1:0] pend_own;
  logic [CW-1:0] n_out;

  // status toward the controller
  dtq_pkg::chk_kind_t chk_kind;
  dtq_pkg::dec_kind_t dec_kind;
  logic               scan_done;

  assign sts = '{chk: chk_kind, scan_done: scan_done, dec: dec_kind};

  // read port of the table
  logic [SW-1:0] rd;
  logic          rd_used, rd_isd;
  logic [OW-1:0] rd_own;
  logic [SW-1:0] rd_rank;
  logic [62:0]   rd_dl;
  logic [63:0]   rd_ms;

  assign rd      = cmd.scan_step ? idx : r_tid[SW-1:0];
  assign rd_used = used[rd];
  assign rd_isd  = isd[rd];
  assign rd_own  = owner[rd];
  assign rd_rank = rank[rd];
  assign rd_dl   = dl[rd];
  assign rd_ms   = ms[rd];

  // checks on the request
  logic [63:0]   sum;
  logic          own_bad, is_add, is_delay_req;
  logic [CW-1:0] nlim, dlim;
  logic [OW-1:0] own_m1;

  assign sum     = {1'b0, r_el} + {1'b0, r_dur};
  assign own_bad = (r_own == 5'd0) || (r_own > 5'(dtq_pkg::OWNERS));
  assign own_m1  = OW'(r_own - 5'd1);
  assign nlim    = (next_limit < CW'(dtq_pkg::DEPTH_NEXT)) ? next_limit
                                                          : CW'(dtq_pkg::DEPTH_NEXT);
  assign dlim    = (delay_limit < CW'(dtq_pkg::DEPTH_DELAY)) ? delay_limit
                                                            : CW'(dtq_pkg::DEPTH_DELAY);
  assign is_add       = (r_type == dtq_pkg::REQ_ADD_NEXT) || (r_type == dtq_pkg::REQ_ADD_DELAY);
  assign is_delay_req = (r_type == dtq_pkg::REQ_ADD_DELAY) || (r_type == dtq_pkg::REQ_PROMO_DLY);

  logic       chk_rm;
  logic [2:0] chk_status;

  always_comb begin
    chk_kind   = dtq_pkg::CK_SCAN;
    chk_status = dtq_pkg::ST_OK;
    chk_rm     = 1'b0;
    unique case (r_type)
      dtq_pkg::REQ_ADD_NEXT: begin
        chk_kind = dtq_pkg::CK_RESULT;
        if (stopping) chk_status = dtq_pkg::ST_STOPPING;
        else if (&r_st) chk_status = dtq_pkg::ST_OVERFLOW;
        else if (fifo_count >= nlim) chk_status = dtq_pkg::ST_CAPACITY;
        else if (own_bad) chk_status = dtq_pkg::ST_STOPPING;
        else chk_kind = dtq_pkg::CK_SCAN;
      end
      dtq_pkg::REQ_ADD_DELAY: begin
        chk_kind = dtq_pkg::CK_RESULT;
        if (stopping) chk_status = dtq_pkg::ST_STOPPING;
        else if ((&r_st) || sum[63]) chk_status = dtq_pkg::ST_OVERFLOW;
        else if (heap_count >= dlim) chk_status = dtq_pkg::ST_CAPACITY;
        else if (&order_cnt) chk_status = dtq_pkg::ST_OVERFLOW;
        else if (own_bad) chk_status = dtq_pkg::ST_STOPPING;
        else chk_kind = dtq_pkg::CK_SCAN;
      end
      dtq_pkg::REQ_CANCEL_ID: begin
        chk_kind = dtq_pkg::CK_RESULT;
        if (rd_used) chk_rm = 1'b1;
        else chk_status = dtq_pkg::ST_NOTFOUND;
      end
      dtq_pkg::REQ_CANCEL_OWN: begin
        if (own_bad) begin
          chk_kind   = dtq_pkg::CK_RESULT;
          chk_status = dtq_pkg::ST_NOTFOUND;
        end
      end
      dtq_pkg::REQ_PROMO_NEXT, dtq_pkg::REQ_PROMO_DLY: chk_kind = dtq_pkg::CK_SCAN;
      default: chk_kind = dtq_pkg::CK_DROP;
    endcase
  end

  // scan candidate at idx
  logic cand, better;

  always_comb begin
    cand   = 1'b0;
    better = !found || (rd_rank > best_rank);
    unique case (r_type)
      dtq_pkg::REQ_ADD_NEXT, dtq_pkg::REQ_ADD_DELAY: begin
        cand   = !rd_used;
        better = !found;
      end
      dtq_pkg::REQ_CANCEL_OWN: begin
        // newest wait of the owner has the lowest rank
        cand   = rd_used && (rd_own == own_m1);
        better = !found || (rd_rank < best_rank);
      end
      dtq_pkg::REQ_PROMO_NEXT: cand = rd_used && !rd_isd;
      dtq_pkg::REQ_PROMO_DLY: begin
        cand   = rd_used && rd_isd;
        better = !found || (rd_dl < best_dl) ||
                 ((rd_dl == best_dl) && (rd_rank > best_rank));
      end
      default: cand = 1'b0;
    endcase
  end

  assign scan_done = (idx == SW'(dtq_pkg::SLOTS - 1));

  // decision after a full scan
  logic due, is_promo, is_own;

  assign is_promo = (r_type == dtq_pkg::REQ_PROMO_NEXT) || (r_type == dtq_pkg::REQ_PROMO_DLY);
  assign is_own   = (r_type == dtq_pkg::REQ_CANCEL_OWN);
  assign due = found && (best_ms <= r_st) && (n_out < CW'(dtq_pkg::MAX_OUT)) &&
               (!is_delay_req || (best_dl <= r_el));

  always_comb begin
    dec_kind = dtq_pkg::DK_FINAL;
    if (is_promo && due) dec_kind = have_pend ? dtq_pkg::DK_MORE : dtq_pkg::DK_RESCAN;
  end

  // table update strobes
  logic          rm_en, add_en;
  logic [SW-1:0] rm_slot, rm_rank;
  logic          rm_delay;

  assign add_en   = cmd.decide && is_add && found;
  assign rm_en    = (cmd.check && chk_rm) ||
                    (cmd.decide && ((is_own && found) || (is_promo && due)));
  assign rm_slot  = cmd.check ? rd : best_id;
  assign rm_rank  = cmd.check ? rd_rank : best_rank;
  assign rm_delay = cmd.check ? rd_isd : best_isd;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_limit  <= 5'd16;
      delay_limit <= 5'd16;
      stopping    <= 1'b0;
      used        <= '0;
      fifo_count  <= '0;
      heap_count  <= '0;
      order_cnt   <= '0;
      have_pend   <= 1'b0;
      n_out       <= '0;
      found       <= 1'b0;
      idx         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          dtq_pkg::CFG_NEXT_LIMIT:  next_limit  <= cfg_wdata;
          dtq_pkg::CFG_DELAY_LIMIT: delay_limit <= cfg_wdata;
          dtq_pkg::CFG_STOPPING:    stopping    <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        r_type    <= req_type;
        r_dur     <= duration_ns;
        r_tid     <= target_id;
        r_own     <= owner_slot;
        r_el      <= now_elapsed;
        r_st      <= now_step;
        have_pend <= 1'b0;
        n_out     <= '0;
      end

      if (cmd.scan_init) begin
        idx   <= '0;
        found <= 1'b0;
      end else if (cmd.scan_step) begin
        idx <= idx + SW'(1);
        if (cand && better) begin
          found     <= 1'b1;
          best_id   <= rd;
          best_rank <= rd_rank;
          best_isd  <= rd_isd;
          best_dl   <= rd_dl;
          best_ms   <= rd_ms;
          best_own  <= rd_own;
        end
      end

      // ranks: 0 is the newest live wait
      for (int i = 0; i < dtq_pkg::SLOTS; i++) begin
        if (add_en && used[i]) rank[i] <= rank[i] + SW'(1);
        if (rm_en && used[i] && (rank[i] > rm_rank)) rank[i] <= rank[i] - SW'(1);
      end

      if (add_en) begin
        used[best_id]  <= 1'b1;
        isd[best_id]   <= is_delay_req;
        owner[best_id] <= own_m1;
        rank[best_id]  <= '0;
        dl[best_id]    <= sum[62:0];
        ms[best_id]    <= r_st + 64'd1;
        if (is_delay_req) begin
          heap_count <= heap_count + CW'(1);
          order_cnt  <= order_cnt + 64'd1;
        end else begin
          fifo_count <= fifo_count + CW'(1);
        end
      end

      if (rm_en) begin
        used[rm_slot] <= 1'b0;
        if (rm_delay) heap_count <= heap_count - CW'(1);
        else fifo_count <= fifo_count - CW'(1);
      end

      if (cmd.check && (chk_kind == dtq_pkg::CK_RESULT)) begin
        status    <= chk_status;
        out_id    <= (r_type == dtq_pkg::REQ_CANCEL_ID) ? r_tid : 5'd0;
        out_owner <= chk_rm ? 5'({1'b0, rd_own} + 5'd1) : 5'd0;
        last      <= 1'b1;
      end

      if (cmd.decide) begin
        if (is_promo) begin
          if (due) begin
            n_out     <= n_out + CW'(1);
            have_pend <= 1'b1;
            pend_id   <= best_id;
            pend_own  <= best_own;
            if (have_pend) begin
              status    <= dtq_pkg::ST_DUE;
              out_id    <= 5'(pend_id);
              out_owner <= 5'({1'b0, pend_own} + 5'd1);
              last      <= 1'b0;
            end
          end else begin
            status    <= have_pend ? dtq_pkg::ST_DUE : dtq_pkg::ST_NONE_DUE;
            out_id    <= have_pend ? 5'(pend_id) : 5'd0;
            out_owner <= have_pend ? 5'({1'b0, pend_own} + 5'd1) : 5'd0;
            last      <= 1'b1;
          end
        end else begin
          last      <= 1'b1;
          status    <= found ? dtq_pkg::ST_OK
                             : (is_own ? dtq_pkg::ST_NOTFOUND : dtq_pkg::ST_FULL);
          out_id    <= found ? 5'(best_id) : 5'd0;
          out_owner <= !found ? 5'd0 : (is_own ? 5'({1'b0, best_own} + 5'd1) : r_own);
        end
      end
    end
  end

endmodule

// ===== rtl/dtq_ctrl.sv =====
// Controller: sequences load, check, slot scan, decision and result hand-off.
module dtq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output dtq_pkg::cmd_t cmd,
  input  dtq_pkg::sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_OUT} state_t;

  state_t state;
  logic   more;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.check     = (state == S_CHECK);
    cmd.scan_step = (state == S_SCAN);
    cmd.decide    = (state == S_DECIDE);
    cmd.scan_init = ((state == S_CHECK) && (sts.chk == dtq_pkg::CK_SCAN)) ||
                    ((state == S_DECIDE) && (sts.dec == dtq_pkg::DK_RESCAN)) ||
                    ((state == S_OUT) && out_ready && more);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      more      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CHECK;
        S_CHECK: begin
          unique case (sts.chk)
            dtq_pkg::CK_RESULT: begin
              state     <= S_OUT;
              out_valid <= 1'b1;
              more      <= 1'b0;
            end
            dtq_pkg::CK_SCAN: state <= S_SCAN;
            default: state <= S_IDLE;
          endcase
        end
        S_SCAN: if (sts.scan_done) state <= S_DECIDE;
        S_DECIDE: begin
          unique case (sts.dec)
            dtq_pkg::DK_RESCAN: state <= S_SCAN;
            dtq_pkg::DK_MORE: begin
              state     <= S_OUT;
              out_valid <= 1'b1;
              more      <= 1'b1;
            end
            default: begin
              state     <= S_OUT;
              out_valid <= 1'b1;
              more      <= 1'b0;
            end
          endcase
        end
        S_OUT: begin
          // hold the result until taken
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= more ? S_SCAN : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/deadline_timer_queue_top.sv =====
// Top level of the deadline timer queue: controller plus datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | req_type duration_ns target_id owner_slot
//          |                      | now_elapsed now_step
//  out     | out_valid/out_ready  | status out_id out_owner last
//  cfg     | cfg_we               | cfg_idx cfg_wdata
//
// A request is taken only when the block is idle. Requests settled by the check
// alone (refused adds, cancel by id, cancel-newest with a bad owner) have their
// result registered in the check state. Adds, cancel-newest and promotes scan
// all 32 slots, one slot a cycle, with the result registered in the decision
// state; a promote rescans after each due wait. Reset empties the slot table,
// clears the counters and sets both limits to 16. A stalled result holds the
// block until taken.
module deadline_timer_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [62:0] duration_ns,
  input  logic [4:0]  target_id,
  input  logic [4:0]  owner_slot,
  input  logic [62:0] now_elapsed,
  input  logic [63:0] now_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [4:0]  out_id,
  output logic [4:0]  out_owner,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [4:0]  cfg_wdata
);

  dtq_pkg::cmd_t cmd;
  dtq_pkg::sts_t sts;

  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  dtq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .req_type    (req_type),
    .duration_ns (duration_ns),
    .target_id   (target_id),
    .owner_slot  (owner_slot),
    .now_elapsed (now_elapsed),
    .now_step    (now_step),
    .status      (status),
    .out_id      (out_id),
    .out_owner   (out_owner),
    .last        (last)
  );

endmodule
